// File: rtl/mhs_pkg.sv
`timescale 1ns / 1ps
package mhs_pkg;

   localparam logic [63:0] SEED_ONE = 64'hae27729cb202352b;
   localparam logic [63:0] SEED_TWO = 64'hd5e7551b9199b903;
   localparam logic [63:0] MUL_A    = 64'h87c37b91114253d5;
   localparam logic [63:0] MUL_B    = 64'h4cf5ad432745937f;
   localparam logic [63:0] ADD_ONE  = 64'h0000000052dce729;
   localparam logic [63:0] ADD_TWO  = 64'h0000000038495ab5;
   localparam logic [63:0] FMIX_A   = 64'hff51afd7ed558ccd;
   localparam logic [63:0] FMIX_B   = 64'hc4ceb9fe1a85ec53;

   localparam logic [4:0] FULL_COUNT = 5'd16;
   localparam logic [4:0] WORD_COUNT = 5'd8;

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_FILL_W = $clog2(FIFO_DEPTH + 1);

   typedef enum logic {
      OP_ROUND,
      OP_TAIL
   } op_type;

   typedef struct packed {
      op_type      op;
      logic        last;
      logic [4:0]  count;
      logic [63:0] lo;
      logic [63:0] hi;
   } item_type;

   typedef struct packed {
      logic     push;
      item_type item;
   } fifo_wr_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } fifo_rd_type;

   typedef struct packed {
      logic        start;
      logic [63:0] op_a;
      logic [63:0] op_b;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] prod;
   } mul_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_K1A,
      ST_K1B,
      ST_K2A,
      ST_K2B,
      ST_MIX1,
      ST_MIX1B,
      ST_MIX2,
      ST_MIX2B,
      ST_FIN0,
      ST_FIN1,
      ST_FM1A,
      ST_FM1B,
      ST_FM2A,
      ST_FM2B,
      ST_OUT0,
      ST_OUT1
   } state_type;

endpackage

// File: rtl/murmur3_128bit_stream_hash_top.sv
`timescale 1ns / 1ps
// MurmurHash3 x64_128 over a byte string streamed as 16-byte blocks.
// Request channel (req_*): one block per request, word_low holding bytes 0..7
// and word_high bytes 8..15, little endian. byte_count applies only with
// last_block set; counts above 16 act as 16, bytes past the count are ignored.
// Response channel (rsp_*): one 128-bit hash per last block, nothing otherwise.
// Requests enter a two-entry queue; a sequencer with one shared 32x32
// multiplier (three partial products per 64-bit product) works through
// them. A last block's hash is registered after the two fmix64 passes,
// which add four more products.
// The hash sits in an output register; while it waits, the next blocks are
// still taken and hashed, and only the next hash stalls until rsp_ready.
// Synchronous reset empties the queue, drops any pending response and loads
// the two seed words with a zero length.
module murmur3_128bit_stream_hash_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_word_low,
   input  logic [63:0] req_word_high,
   input  logic [4:0]  req_byte_count,
   input  logic        req_last_block,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_hash_low,
   output logic [63:0] rsp_hash_high
);
   import mhs_pkg::*;

   fifo_wr_type wr;
   fifo_rd_type rd;
   mul_req_type mreq;
   mul_rsp_type mrsp;
   logic        full;
   logic        pop;

   mhs_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_word_low   (req_word_low),
      .req_word_high  (req_word_high),
      .req_byte_count (req_byte_count),
      .req_last_block (req_last_block),
      .full           (full),
      .wr             (wr)
   );

   mhs_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .full  (full),
      .pop   (pop),
      .rd    (rd)
   );

   mhs_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mreq),
      .rsp   (mrsp)
   );

   mhs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .rd            (rd),
      .pop           (pop),
      .mreq          (mreq),
      .mrsp          (mrsp),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_hash_low  (rsp_hash_low),
      .rsp_hash_high (rsp_hash_high)
   );

endmodule

// File: rtl/mhs_fifo.sv
`timescale 1ns / 1ps
module mhs_fifo (
   input  logic                clock,
   input  logic                reset,
   input  mhs_pkg::fifo_wr_type wr,
   output logic                full,
   input  logic                pop,
   output mhs_pkg::fifo_rd_type rd
);
   import mhs_pkg::*;

   item_type               entries_ff [FIFO_DEPTH];
   item_type               entries_in [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_FILL_W-1:0] fill_ff, fill_in;
   logic                   push_ok, pop_ok;

   assign full    = (fill_ff == FIFO_FILL_W'(FIFO_DEPTH));
   assign push_ok = wr.push && !full;
   assign pop_ok  = pop && (fill_ff != '0);

   assign rd.valid = (fill_ff != '0);
   assign rd.item  = entries_ff[rd_ptr_ff];

   always_comb begin
      entries_in = entries_ff;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      fill_in    = fill_ff;
      if (push_ok) begin
         entries_in[wr_ptr_ff] = wr.item;
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FIFO_FILL_W'(FIFO_DEPTH))
      else $error("queue fill beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> rd.valid)
      else $error("pop from empty queue");

   a_fill_grows: assert property (@(posedge clock) disable iff (reset)
      (push_ok && !pop_ok) |=> fill_ff == FIFO_FILL_W'($past(fill_ff) + 1'b1))
      else $error("queue fill lost a push");
`endif

endmodule

// File: rtl/mhs_front.sv
`timescale 1ns / 1ps
module mhs_front (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [63:0]          req_word_low,
   input  logic [63:0]          req_word_high,
   input  logic [4:0]           req_byte_count,
   input  logic                 req_last_block,
   input  logic                 full,
   output mhs_pkg::fifo_wr_type wr
);
   import mhs_pkg::*;

   // mask keeping the low n bytes, n in 0..8
   function automatic logic [63:0] low_bytes(input logic [3:0] n);
      logic [63:0] m;
      if (n >= 4'd8) begin
         m = '1;
      end else begin
         m = (64'd1 << {n[2:0], 3'b000}) - 64'd1;
      end
      return m;
   endfunction

   logic [4:0] sat_count;
   logic [4:0] hi_count;
   logic [3:0] lo_n, hi_n;

   assign req_ready = !full;
   assign sat_count = (req_byte_count > FULL_COUNT) ? FULL_COUNT : req_byte_count;
   assign hi_count  = sat_count - WORD_COUNT;
   assign lo_n      = (sat_count > WORD_COUNT) ? 4'd8 : sat_count[3:0];
   assign hi_n      = (sat_count > WORD_COUNT) ? hi_count[3:0] : 4'd0;

   always_comb begin
      wr.push      = req_valid;
      wr.item.last = req_last_block;
      priority if (!req_last_block || sat_count == FULL_COUNT) begin
         wr.item.op    = OP_ROUND;
         wr.item.count = FULL_COUNT;
         wr.item.lo    = req_word_low;
         wr.item.hi    = req_word_high;
      end else begin
         // partial or empty tail: zeroed words premix to zero
         wr.item.op    = OP_TAIL;
         wr.item.count = sat_count;
         wr.item.lo    = req_word_low & low_bytes(lo_n);
         wr.item.hi    = req_word_high & low_bytes(hi_n);
      end
   end

endmodule

// File: rtl/mhs_mul.sv
`timescale 1ns / 1ps
module mhs_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  mhs_pkg::mul_req_type req,
   output mhs_pkg::mul_rsp_type rsp
);
   import mhs_pkg::*;

   localparam logic [1:0] STEP_LL = 2'd0;
   localparam logic [1:0] STEP_LH = 2'd1;
   localparam logic [1:0] STEP_HL = 2'd2;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [1:0]  step_ff, step_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] x, y;
   logic [63:0] pp;

   // low 64 bits of a*b: lo*lo, then both cross terms shifted by 32
   assign x  = (step_ff == STEP_HL) ? a_ff[63:32] : a_ff[31:0];
   assign y  = (step_ff == STEP_LH) ? b_ff[63:32] : b_ff[31:0];
   assign pp = x * y;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      prod_in = prod_ff;
      if (req.start) begin
         busy_in = 1'b1;
         step_in = STEP_LL;
         a_in    = req.op_a;
         b_in    = req.op_b;
      end else if (busy_ff) begin
         prod_in = (step_ff == STEP_LL) ? pp : prod_ff + {pp[31:0], 32'd0};
         if (step_ff == STEP_HL) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.prod = prod_ff;

endmodule

// File: rtl/mhs_back.sv
`timescale 1ns / 1ps
module mhs_back (
   input  logic                 clock,
   input  logic                 reset,
   input  mhs_pkg::fifo_rd_type rd,
   output logic                 pop,
   output mhs_pkg::mul_req_type mreq,
   input  mhs_pkg::mul_rsp_type mrsp,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [63:0]          rsp_hash_low,
   output logic [63:0]          rsp_hash_high
);
   import mhs_pkg::*;

   function automatic logic [63:0] shx(input logic [63:0] v);
      return v ^ {33'd0, v[63:33]};
   endfunction

   state_type   state_ff, state_in;
   op_type      op_ff, op_in;
   logic        last_ff, last_in;
   logic [63:0] lo_ff, lo_in;
   logic [63:0] hi_ff, hi_in;
   logic [63:0] k1_ff, k1_in;
   logic [63:0] k2_ff, k2_in;
   logic [63:0] acc1_ff, acc1_in;
   logic [63:0] acc2_ff, acc2_in;
   logic [63:0] len_ff, len_in;
   logic [63:0] h1_ff, h1_in;
   logic [63:0] h2_ff, h2_in;
   logic [63:0] hash_low_ff, hash_low_in;
   logic [63:0] hash_high_ff, hash_high_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        mul_wait_ff, mul_wait_in;
   logic        is_mul;
   logic        out_load;
   logic [63:0] mix_one, mix_two;

   assign mix_one = acc1_ff ^ k1_ff;
   assign mix_two = acc2_ff ^ k2_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (rd.valid) state_in = ST_K1A;
         ST_K1A:   if (mrsp.done) state_in = ST_K1B;
         ST_K1B:   if (mrsp.done) state_in = ST_K2A;
         ST_K2A:   if (mrsp.done) state_in = ST_K2B;
         ST_K2B:   if (mrsp.done) state_in = ST_MIX1;
         ST_MIX1:  state_in = (op_ff == OP_TAIL) ? ST_FIN0 : ST_MIX1B;
         ST_MIX1B: state_in = ST_MIX2;
         ST_MIX2:  state_in = ST_MIX2B;
         ST_MIX2B: state_in = last_ff ? ST_FIN0 : ST_IDLE;
         ST_FIN0:  state_in = ST_FIN1;
         ST_FIN1:  state_in = ST_FM1A;
         ST_FM1A:  if (mrsp.done) state_in = ST_FM1B;
         ST_FM1B:  if (mrsp.done) state_in = ST_FM2A;
         ST_FM2A:  if (mrsp.done) state_in = ST_FM2B;
         ST_FM2B:  if (mrsp.done) state_in = ST_OUT0;
         ST_OUT0:  state_in = ST_OUT1;
         ST_OUT1:  if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      is_mul    = 1'b0;
      mreq.op_a = '0;
      mreq.op_b = '0;
      unique case (state_ff)
         ST_K1A: begin
            is_mul = 1'b1; mreq.op_a = lo_ff; mreq.op_b = MUL_A;
         end
         ST_K1B: begin
            is_mul = 1'b1; mreq.op_a = {k1_ff[32:0], k1_ff[63:33]}; mreq.op_b = MUL_B;
         end
         ST_K2A: begin
            is_mul = 1'b1; mreq.op_a = hi_ff; mreq.op_b = MUL_B;
         end
         ST_K2B: begin
            is_mul = 1'b1; mreq.op_a = {k2_ff[30:0], k2_ff[63:31]}; mreq.op_b = MUL_A;
         end
         ST_FM1A: begin
            is_mul = 1'b1; mreq.op_a = shx(h1_ff); mreq.op_b = FMIX_A;
         end
         ST_FM1B: begin
            is_mul = 1'b1; mreq.op_a = shx(h1_ff); mreq.op_b = FMIX_B;
         end
         ST_FM2A: begin
            is_mul = 1'b1; mreq.op_a = shx(h2_ff); mreq.op_b = FMIX_A;
         end
         ST_FM2B: begin
            is_mul = 1'b1; mreq.op_a = shx(h2_ff); mreq.op_b = FMIX_B;
         end
         default: begin
            is_mul = 1'b0;
         end
      endcase
      mreq.start = is_mul && !mul_wait_ff;
      pop        = (state_ff == ST_IDLE) && rd.valid;
      out_load   = (state_ff == ST_OUT1) && (!rsp_valid_ff || rsp_ready);
   end

   // datapath
   always_comb begin
      op_in        = op_ff;
      last_in      = last_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      k1_in        = k1_ff;
      k2_in        = k2_ff;
      acc1_in      = acc1_ff;
      acc2_in      = acc2_ff;
      len_in       = len_ff;
      h1_in        = h1_ff;
      h2_in        = h2_ff;
      hash_low_in  = hash_low_ff;
      hash_high_in = hash_high_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      mul_wait_in  = mrsp.done ? 1'b0 : (mreq.start ? 1'b1 : mul_wait_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (rd.valid) begin
               op_in   = rd.item.op;
               last_in = rd.item.last;
               lo_in   = rd.item.lo;
               hi_in   = rd.item.hi;
               len_in  = len_ff + {59'd0, rd.item.count};
            end
         end
         ST_K1A, ST_K1B: if (mrsp.done) k1_in = mrsp.prod;
         ST_K2A, ST_K2B: if (mrsp.done) k2_in = mrsp.prod;
         ST_MIX1: begin
            if (op_ff == OP_TAIL) begin
               acc1_in = mix_one;
               acc2_in = mix_two;
            end else begin
               acc1_in = {mix_one[36:0], mix_one[63:37]} + acc2_ff;
            end
         end
         ST_MIX1B: acc1_in = {acc1_ff[61:0], 2'b00} + acc1_ff + ADD_ONE;
         ST_MIX2:  acc2_in = {mix_two[32:0], mix_two[63:33]} + acc1_ff;
         ST_MIX2B: acc2_in = {acc2_ff[61:0], 2'b00} + acc2_ff + ADD_TWO;
         ST_FIN0: begin
            h1_in = (acc1_ff ^ len_ff) + (acc2_ff ^ len_ff);
            h2_in = acc2_ff ^ len_ff;
         end
         ST_FIN1: h2_in = h2_ff + h1_ff;
         ST_FM1A: if (mrsp.done) h1_in = mrsp.prod;
         ST_FM1B: if (mrsp.done) h1_in = shx(mrsp.prod);
         ST_FM2A: if (mrsp.done) h2_in = mrsp.prod;
         ST_FM2B: if (mrsp.done) h2_in = shx(mrsp.prod);
         ST_OUT0: h1_in = h1_ff + h2_ff;
         ST_OUT1: begin
            if (out_load) begin
               hash_low_in  = h1_ff;
               hash_high_in = h2_ff + h1_ff;
               rsp_valid_in = 1'b1;
               acc1_in      = SEED_ONE;
               acc2_in      = SEED_TWO;
               len_in       = '0;
            end
         end
         default: begin
            op_in = op_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      last_ff      <= last_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      k1_ff        <= k1_in;
      k2_ff        <= k2_in;
      h1_ff        <= h1_in;
      h2_ff        <= h2_in;
      hash_low_ff  <= hash_low_in;
      hash_high_ff <= hash_high_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc1_ff      <= SEED_ONE;
         acc2_ff      <= SEED_TWO;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         mul_wait_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc1_ff      <= acc1_in;
         acc2_ff      <= acc2_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
         mul_wait_ff  <= mul_wait_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hash_low  = hash_low_ff;
   assign rsp_hash_high = hash_high_ff;

`ifndef SYNTHESIS
   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      mrsp.done |-> mul_wait_ff)
      else $error("multiplier result with no operation outstanding");

   a_result_restarts: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff && acc1_ff == SEED_ONE && acc2_ff == SEED_TWO
                   && len_ff == '0)
      else $error("state not back at seeds after a hash");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT1 && rsp_valid_ff && !rsp_ready) |=> state_ff == ST_OUT1)
      else $error("hash overwrote a waiting result");
`endif

endmodule

// File: tb/murmur3_128bit_stream_hash_top_test.sv
`timescale 1ns / 1ps

// Tracks the running hash state of the stream and the hashes still owed.
class hash_scoreboard;
   localparam logic [63:0] START_A = 64'hae27729cb202352b;
   localparam logic [63:0] START_B = 64'hd5e7551b9199b903;
   localparam logic [63:0] K_ONE   = 64'h87c37b91114253d5;
   localparam logic [63:0] K_TWO   = 64'h4cf5ad432745937f;
   localparam logic [63:0] BIAS_A  = 64'h0000000052dce729;
   localparam logic [63:0] BIAS_B  = 64'h0000000038495ab5;
   localparam logic [63:0] AVAL_A  = 64'hff51afd7ed558ccd;
   localparam logic [63:0] AVAL_B  = 64'hc4ceb9fe1a85ec53;

   logic [63:0] acc_a;
   logic [63:0] acc_b;
   logic [63:0] byte_total;
   logic [63:0] owed_low[$];
   logic [63:0] owed_high[$];
   int          errors;
   int          hashes_checked;
   int          strings;

   function new();
      acc_a = START_A;
      acc_b = START_B;
      byte_total = 64'd0;
      errors = 0;
      hashes_checked = 0;
      strings = 0;
   endfunction

   function logic [63:0] rotl(logic [63:0] v, int unsigned s);
      return (v << s) | (v >> (64 - s));
   endfunction

   function logic [63:0] avalanche(logic [63:0] v);
      v = v ^ (v >> 33);
      v = v * AVAL_A;
      v = v ^ (v >> 33);
      v = v * AVAL_B;
      v = v ^ (v >> 33);
      return v;
   endfunction

   function logic [63:0] scramble_low(logic [63:0] k);
      k = k * K_ONE;
      k = rotl(k, 31);
      return k * K_TWO;
   endfunction

   function logic [63:0] scramble_high(logic [63:0] k);
      k = k * K_TWO;
      k = rotl(k, 33);
      return k * K_ONE;
   endfunction

   function logic [63:0] keep_bytes(int unsigned n);
      if (n >= 8)
         return '1;
      return (64'd1 << (8 * n)) - 64'd1;
   endfunction

   function void mix_block(logic [63:0] lo, logic [63:0] hi);
      acc_a = acc_a ^ scramble_low(lo);
      acc_a = rotl(acc_a, 27);
      acc_a = acc_a + acc_b;
      acc_a = acc_a * 64'd5 + BIAS_A;
      acc_b = acc_b ^ scramble_high(hi);
      acc_b = rotl(acc_b, 31);
      acc_b = acc_b + acc_a;
      acc_b = acc_b * 64'd5 + BIAS_B;
   endfunction

   // Called for every accepted request.
   function void note_block(logic [63:0] lo, logic [63:0] hi, logic [4:0] count, logic fin);
      int unsigned n;
      logic [63:0] h1;
      logic [63:0] h2;
      if (!fin) begin
         mix_block(lo, hi);
         byte_total = byte_total + 64'd16;
         return;
      end
      n = (count > 16) ? 16 : count;
      if (n == 16) begin
         mix_block(lo, hi);
      end else if (n > 0) begin
         if (n > 8)
            acc_b = acc_b ^ scramble_high(hi & keep_bytes(n - 8));
         acc_a = acc_a ^ scramble_low(lo & keep_bytes((n > 8) ? 8 : n));
      end
      byte_total = byte_total + 64'(n);
      h1 = acc_a ^ byte_total;
      h2 = acc_b ^ byte_total;
      h1 = h1 + h2;
      h2 = h2 + h1;
      h1 = avalanche(h1);
      h2 = avalanche(h2);
      h1 = h1 + h2;
      h2 = h2 + h1;
      owed_low.push_back(h1);
      owed_high.push_back(h2);
      strings++;
      acc_a = START_A;
      acc_b = START_B;
      byte_total = 64'd0;
   endfunction

   function void check_hash(logic [63:0] lo, logic [63:0] hi);
      logic [63:0] want_lo;
      logic [63:0] want_hi;
      if (owed_low.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("tb: unexpected hash %h_%h at %0t", hi, lo, $realtime);
         return;
      end
      want_lo = owed_low.pop_front();
      want_hi = owed_high.pop_front();
      hashes_checked++;
      if (lo !== want_lo || hi !== want_hi) begin
         errors++;
         if (errors <= 10)
            $display("tb: hash %0d mismatch: low exp %h got %h, high exp %h got %h",
                     hashes_checked, want_lo, lo, want_hi, hi);
      end
   endfunction

   function int pending();
      return owed_low.size();
   endfunction
endclass

module murmur3_128bit_stream_hash_top_test;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int BLOCK_TARGET   = 1550;
   localparam int DRAIN_CYCLES   = 80;
   localparam logic [63:0] ONES  = '1;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_word_low;
   logic [63:0] req_word_high;
   logic [4:0]  req_byte_count;
   logic        req_last_block;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_hash_low;
   logic [63:0] rsp_hash_high;

   bit             steady;
   int             blocks_sent;
   int             quiet_cycles;
   hash_scoreboard sb;

   murmur3_128bit_stream_hash_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_word_low   (req_word_low),
      .req_word_high  (req_word_high),
      .req_byte_count (req_byte_count),
      .req_last_block (req_last_block),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_low   (rsp_hash_low),
      .rsp_hash_high  (rsp_hash_high)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_word_low = 64'd0;
      req_word_high = 64'd0;
      req_byte_count = 5'd0;
      req_last_block = 1'b0;
      rsp_ready = 1'b0;
      steady = 1'b0;
      blocks_sent = 0;
      quiet_cycles = 0;
      sb = new();
   end

   function automatic logic [63:0] random_word();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         return 64'd0;
      if (pick == 1)
         return ONES;
      return {$urandom, $urandom};
   endfunction

   // One request; valid held with the payload until the DUT takes it.
   task automatic send_block(logic [63:0] lo, logic [63:0] hi, logic [4:0] count, logic fin);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 35) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word_low <= lo;
      req_word_high <= hi;
      req_byte_count <= count;
      req_last_block <= fin;
      do
         @(posedge clock);
      while (!req_ready);
      sb.note_block(lo, hi, count, fin);
      blocks_sent++;
   endtask

   initial begin
      forever begin
         @(negedge clock);
         rsp_ready <= steady || ($urandom_range(0, 99) >= 35);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_hash(rsp_hash_low, rsp_hash_high);
   end

   initial begin
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: no progress for %0d cycles, %0d hashes outstanding",
                     quiet_cycles, sb.pending());
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      int          nblk;
      logic [4:0]  cnt;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // empty string, then tails across the word boundary
      send_block(64'd0, 64'd0, 5'd0, 1'b1);
      send_block(ONES, ONES, 5'd1, 1'b1);
      send_block(ONES, ONES, 5'd7, 1'b1);
      send_block(ONES, ONES, 5'd8, 1'b1);
      send_block(ONES, ONES, 5'd9, 1'b1);
      send_block(ONES, ONES, 5'd15, 1'b1);
      send_block(64'd0, 64'd0, 5'd16, 1'b1);
      send_block(ONES, ONES, 5'd16, 1'b1);
      // oversized counts saturate to a full block
      send_block(ONES, ONES, 5'd31, 1'b1);
      send_block(ONES, 64'd0, 5'd17, 1'b1);
      // full block followed by an empty last block
      send_block(ONES, ONES, 5'd0, 1'b0);
      send_block(64'd0, 64'd0, 5'd0, 1'b1);
      // count ignored on a block that is not last
      send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd31, 1'b0);
      send_block(ONES, ONES, 5'd5, 1'b1);
      send_block(ONES, 64'd0, 5'd16, 1'b0);
      send_block(64'd0, ONES, 5'd16, 1'b0);
      send_block(ONES, ONES, 5'd12, 1'b1);

      while (blocks_sent < BLOCK_TARGET) begin
         steady = (blocks_sent >= 700 && blocks_sent < 1000);
         nblk = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 40) : $urandom_range(1, 5);
         for (int i = 1; i < nblk; i++)
            send_block(random_word(), random_word(), 5'($urandom_range(0, 31)), 1'b0);
         if ($urandom_range(0, 9) == 0)
            cnt = 5'($urandom_range(17, 31));
         else
            cnt = 5'($urandom_range(0, 16));
         send_block(random_word(), random_word(), cnt, 1'b1);
      end
      steady = 1'b0;
      @(negedge clock);
      req_valid <= 1'b0;

      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d blocks in %0d strings hashed, %0d hashes compared", blocks_sent,
               sb.strings, sb.hashes_checked);
      $display("tb: covered empty strings, all tail lengths, oversized counts, %0d errors",
               sb.errors);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
